FILE: design/homogeneous_point_transform_unit_assert.svh
// Assertion helpers for the point transform unit.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_UNIT_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define HPT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hpt assertion failed");
`define HPT_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("hpt hold assertion failed");
`else
`define HPT_ASSERT(name, clk, rst_n, prop)
`define HPT_ASSERT_HOLD(name, clk, rst_n, cond, sig)
`endif

`endif

FILE: design/hpt_pkg.sv
`timescale 1ns / 1ps
package hpt_pkg;

  localparam int CoordW = 32;
  localparam int QuoW   = 33;
  localparam int NumRegs = 8;

  typedef enum logic {
    MODE_POINT = 1'b0,
    MODE_DIR   = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5,
    REG_ROW3_C01 = 3'd6,
    REG_ROW3_C23 = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic                     mode;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] result_x;
    logic signed [CoordW-1:0] result_y;
    logic signed [CoordW-1:0] result_z;
    logic                     saturated;
  } out_t;

endpackage

FILE: design/hpt_if.sv
`timescale 1ns / 1ps
interface hpt_in_if;
  logic         valid;
  logic         ready;
  hpt_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hpt_out_if;
  logic          valid;
  logic          ready;
  hpt_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/homogeneous_point_transform_unit.sv
`timescale 1ns / 1ps
// Homogeneous 4x4 point transform with perspective divide, fixed point.
// in_i carries one point (mode, x, y, z) per transfer, out_o one result
// (x, y, z, saturated). Both are valid/ready channels; a transfer happens
// when valid and ready are high at a rising edge of clk_i.
// The matrix lives in eight 64-bit registers on the APB port, register i at
// byte address 8*i; write them only while no point is in flight.
// Throughput: one point per cycle while out_o is not stalled. A point passes
// through 37 register stages (multiply, row sum, divide setup, one stage per
// quotient bit for 33 bits, saturation into the output register) before
// out_o.valid rises.
// Every stage advances together: when out_o holds a result that is not
// taken, the whole pipeline freezes and in_i.ready drops; nothing is lost.
// rst_ni (async, active low) empties the pipeline and loads the identity
// matrix. Point mode divides by w unless w is zero or one; direction mode
// uses only the 3x3 part. Out-of-range results clamp and set saturated.
module homogeneous_point_transform_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hpt_in_if.sink      in_i,
  hpt_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import hpt_pkg::*;

  localparam int SW = 66 - FRAC_BITS;      // width of a shifted row sum
  localparam int NW = SW + FRAC_BITS;      // dividend width
  localparam int NL = 3;
  localparam logic [63:0] One64 = 64'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] OneSw = SW'(1) << FRAC_BITS;

  // ---------------- configuration ----------------
  logic [63:0] cfg_q [NumRegs];
  logic        cfg_we;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[5:3]);
  assign cfg_we  = psel && penable && pwrite;
  assign prdata  = cfg_q[paddr[5:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_ROW0_C01] <= One64 << 32;
      cfg_q[REG_ROW0_C23] <= '0;
      cfg_q[REG_ROW1_C01] <= One64;
      cfg_q[REG_ROW1_C23] <= '0;
      cfg_q[REG_ROW2_C01] <= '0;
      cfg_q[REG_ROW2_C23] <= One64 << 32;
      cfg_q[REG_ROW3_C01] <= '0;
      cfg_q[REG_ROW3_C23] <= One64;
    end else if (cfg_we) begin
      cfg_q[cfg_idx] <= pwdata;
    end
  end

  logic signed [CoordW-1:0] m [4][4];
  for (genvar r = 0; r < 4; r++) begin : g_mat
    assign m[r][0] = cfg_q[2*r][63:32];
    assign m[r][1] = cfg_q[2*r][31:0];
    assign m[r][2] = cfg_q[2*r+1][63:32];
    assign m[r][3] = cfg_q[2*r+1][31:0];
  end

  logic pipe_en;
  logic out_vld_q;
  assign pipe_en    = !out_vld_q || out_o.ready;
  assign in_i.ready = pipe_en;

  // ---------------- stage 1: products ----------------
  logic                     v1_q;
  logic                     mode1_q;
  logic signed [63:0]       prod_q [4][3];
  logic signed [CoordW-1:0] tr_q [4];
  logic signed [CoordW-1:0] pin [3];

  assign pin[0] = in_i.data.point_x;
  assign pin[1] = in_i.data.point_y;
  assign pin[2] = in_i.data.point_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mode1_q <= in_i.data.mode;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= m[r][c] * pin[c];
        end
        tr_q[r] <= (in_i.data.mode == MODE_DIR) ? '0 : m[r][3];
      end
    end
  end

  // ---------------- stage 2: row sums ----------------
  logic                 v2_q;
  logic                 mode2_q;
  logic signed [SW-1:0] sum_q [4];
  logic signed [65:0]   acc [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      acc[r] = 66'(prod_q[r][0]) + 66'(prod_q[r][1]) + 66'(prod_q[r][2])
             + (66'(tr_q[r]) <<< FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (pipe_en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mode2_q <= mode1_q;
      for (int r = 0; r < 4; r++) begin
        sum_q[r] <= SW'(acc[r] >>> FRAC_BITS);
      end
    end
  end

  // ---------------- stage 3: divide setup, then one quotient bit a stage ----------------
  // No divide is done as a divide by one: (s << F) / (1 << F) == s.
  logic          dv_q   [QuoW+1];
  logic [SW-1:0] ud_q   [QuoW+1];
  logic [SW-1:0] rem_q  [QuoW+1][NL];
  logic [QuoW-1:0] low_q [QuoW+1][NL];
  logic [QuoW-1:0] quo_q [QuoW+1][NL];
  logic          neg_q  [QuoW+1][NL];
  logic          ovf_q  [QuoW+1][NL];

  logic          nodiv;
  logic          den_neg;
  logic [SW-1:0] ud_d;
  logic [SW-1:0] un [NL];
  logic [NW-1:0] num [NL];

  always_comb begin
    nodiv   = (mode2_q == MODE_DIR) || (sum_q[3] == '0) || (sum_q[3] == OneSw);
    den_neg = !nodiv && sum_q[3][SW-1];
    if (nodiv) begin
      ud_d = OneSw;
    end else begin
      ud_d = den_neg ? SW'(-sum_q[3]) : sum_q[3];
    end
    for (int l = 0; l < NL; l++) begin
      un[l]  = sum_q[l][SW-1] ? SW'(-sum_q[l]) : sum_q[l];
      num[l] = {un[l], {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (pipe_en) begin
      dv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ud_q[0] <= ud_d;
      for (int l = 0; l < NL; l++) begin
        rem_q[0][l] <= SW'(num[l][NW-1:QuoW]);
        low_q[0][l] <= num[l][QuoW-1:0];
        quo_q[0][l] <= '0;
        neg_q[0][l] <= sum_q[l][SW-1] ^ den_neg;
        ovf_q[0][l] <= num[l][NW-1:QuoW] >= ud_d;
      end
    end
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_div
    logic [SW:0] trial [NL];
    logic        ge    [NL];

    always_comb begin
      for (int l = 0; l < NL; l++) begin
        trial[l] = {rem_q[k-1][l], low_q[k-1][l][QuoW-1]};
        ge[l]    = trial[l] >= {1'b0, ud_q[k-1]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (pipe_en) begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        ud_q[k] <= ud_q[k-1];
        for (int l = 0; l < NL; l++) begin
          rem_q[k][l] <= ge[l] ? SW'(trial[l] - {1'b0, ud_q[k-1]}) : SW'(trial[l]);
          low_q[k][l] <= {low_q[k-1][l][QuoW-2:0], 1'b0};
          quo_q[k][l] <= {quo_q[k-1][l][QuoW-2:0], ge[l]};
          neg_q[k][l] <= neg_q[k-1][l];
          ovf_q[k][l] <= ovf_q[k-1][l];
        end
      end
    end
  end

  // ---------------- output: sign and saturation ----------------
  logic [CoordW-1:0] res [NL];
  logic [NL-1:0]     sat;
  out_t              out_d;
  out_t              out_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (neg_q[QuoW][l]) begin
        sat[l] = ovf_q[QuoW][l] || quo_q[QuoW][l] > QuoW'(33'h080000000);
        res[l] = sat[l] ? 32'h80000000 : CoordW'(-quo_q[QuoW][l]);
      end else begin
        sat[l] = ovf_q[QuoW][l] || quo_q[QuoW][l][QuoW-1] || quo_q[QuoW][l][QuoW-2];
        res[l] = sat[l] ? 32'h7FFFFFFF : CoordW'(quo_q[QuoW][l]);
      end
    end
    out_d.result_x  = res[0];
    out_d.result_y  = res[1];
    out_d.result_z  = res[2];
    out_d.saturated = |sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      out_vld_q <= dv_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // ---------------- assertions ----------------
`include "homogeneous_point_transform_unit_assert.svh"

  `HPT_ASSERT(a_out_follows_div, clk_i, rst_ni, pipe_en |=> (out_vld_q == $past(dv_q[QuoW])))
  `HPT_ASSERT_HOLD(a_stall_freezes, clk_i, rst_ni, !pipe_en, {v1_q, v2_q, dv_q[0], dv_q[QuoW]})
  `HPT_ASSERT(a_dir_no_divide, clk_i, rst_ni, (pipe_en && v2_q && mode2_q == MODE_DIR) |=> (ud_q[0] == OneSw))

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import hpt_pkg::*;

  localparam int MaxCycles = 400000;
  localparam int DrainCycles = 60;
  localparam int RandPerPhase = 290;

  typedef struct packed {
    logic         mode;
    logic [31:0]  x;
    logic [31:0]  y;
    logic [31:0]  z;
    logic         typed;
    out_t         result;
  } point_row_t;

  // identity matrix after reset: points pass through unchanged
  localparam point_row_t IdentityRows [12] = '{
    '{MODE_POINT, 32'h0, 32'h0, 32'h0, 1'b1, out_t'{32'h0, 32'h0, 32'h0, 1'b0}},
    '{MODE_POINT, 32'h7fffffff, 32'h80000000, 32'h1, 1'b1,
      out_t'{32'h7fffffff, 32'h80000000, 32'h1, 1'b0}},
    '{MODE_POINT, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1,
      out_t'{32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0}},
    '{MODE_POINT, 32'h00010000, 32'hffff0000, 32'h00008000, 1'b1,
      out_t'{32'h00010000, 32'hffff0000, 32'h00008000, 1'b0}},
    '{MODE_POINT, 32'h55555555, 32'haaaaaaaa, 32'h12345678, 1'b1,
      out_t'{32'h55555555, 32'haaaaaaaa, 32'h12345678, 1'b0}},
    '{MODE_POINT, 32'haaaaaaaa, 32'h55555555, 32'hedcba987, 1'b1,
      out_t'{32'haaaaaaaa, 32'h55555555, 32'hedcba987, 1'b0}},
    '{MODE_DIR, 32'h0, 32'h0, 32'h0, 1'b1, out_t'{32'h0, 32'h0, 32'h0, 1'b0}},
    '{MODE_DIR, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1,
      out_t'{32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0}},
    '{MODE_DIR, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1,
      out_t'{32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0}},
    '{MODE_DIR, 32'hffffffff, 32'h00000001, 32'h00010000, 1'b1,
      out_t'{32'hffffffff, 32'h00000001, 32'h00010000, 1'b0}},
    '{MODE_DIR, 32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 1'b1,
      out_t'{32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 1'b0}},
    '{MODE_DIR, 32'haaaaaaaa, 32'h55555555, 32'hf0f0f0f0, 1'b1,
      out_t'{32'haaaaaaaa, 32'h55555555, 32'hf0f0f0f0, 1'b0}}
  };

  // with w = z: w zero, w one, real divides and overflowing quotients
  localparam point_row_t PerspRows [8] = '{
    '{MODE_POINT, 32'h00030000, 32'h00020000, 32'h0, 1'b0, '0},
    '{MODE_POINT, 32'h00030000, 32'hfffe0000, 32'h00010000, 1'b0, '0},
    '{MODE_POINT, 32'h00030000, 32'h00020000, 32'h00020000, 1'b0, '0},
    '{MODE_POINT, 32'hfffd0000, 32'h00070000, 32'hfffe0000, 1'b0, '0},
    '{MODE_POINT, 32'h7fffffff, 32'h80000000, 32'h00008000, 1'b0, '0},
    '{MODE_POINT, 32'h80000000, 32'h00000001, 32'hffffffff, 1'b0, '0},
    '{MODE_POINT, 32'h00000005, 32'hfffffffb, 32'h00000003, 1'b0, '0},
    '{MODE_DIR, 32'h7fffffff, 32'h00010000, 32'h0, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  hpt_in_if  in_bus ();
  hpt_out_if out_bus ();

  homogeneous_point_transform_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [63:0] matrix [8];
  point_row_t  pending_points [$];
  out_t        expected_results [$];
  point_row_t  cur_point;
  bit          idle_on = 1'b1;
  int          errors = 0;
  int          cycles = 0;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.data = '0;
    out_bus.ready = 1'b0;
  end

  function automatic logic signed [31:0] mat_entry(int r, int c);
    logic [63:0] word;
    word = matrix[2 * r + c / 2];
    return (c % 2) ? word[31:0] : word[63:32];
  endfunction

  function automatic logic signed [95:0] row_dot(int r, in_t d, bit with_transl);
    logic signed [95:0] acc;
    logic signed [95:0] term;
    logic signed [31:0] p [3];
    p[0] = d.point_x;
    p[1] = d.point_y;
    p[2] = d.point_z;
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      term = longint'(mat_entry(r, c)) * longint'(p[c]);
      acc += term;
    end
    if (with_transl) begin
      term = longint'(mat_entry(r, 3)) <<< 16;
      acc += term;
    end
    return acc >>> 16;
  endfunction

  function automatic logic [31:0] clamp32(logic signed [127:0] v, inout logic flag);
    if (v > 128'sh7fffffff) begin
      flag = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sh80000000) begin
      flag = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic out_t transform_point(in_t d);
    logic signed [127:0] sums [3];
    logic signed [127:0] w;
    logic signed [127:0] num;
    logic [31:0] res [3];
    logic flag;
    bit is_point;
    out_t o;
    is_point = (d.mode == MODE_POINT);
    flag = 1'b0;
    for (int r = 0; r < 3; r++) sums[r] = row_dot(r, d, is_point);
    w = is_point ? row_dot(3, d, 1'b1) : 128'sd0;
    for (int r = 0; r < 3; r++) begin
      if (is_point && w != 0 && w != 128'sh10000) begin
        num = sums[r] <<< 16;
        res[r] = clamp32(num / w, flag);  // truncates toward zero
      end else begin
        res[r] = clamp32(sums[r], flag);
      end
    end
    o.result_x = res[0];
    o.result_y = res[1];
    o.result_z = res[2];
    o.saturated = flag;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic apb_write(reg_idx_e idx, logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    matrix[idx] = value;
  endtask

  function automatic logic [31:0] pick_value(bit wide);
    logic [31:0] specials [5];
    specials = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h00010000, 32'hffff0000};
    case ($urandom_range(3))
      0: return $urandom;
      1: return specials[$urandom_range(4)];
      default: return wide ? 32'($signed($urandom_range(2 * 32'h1000000)) - 32'sh1000000)
                           : 32'($signed($urandom_range(2 * 32'h30000)) - 32'sh30000);
    endcase
  endfunction

  task automatic load_random_matrix();
    reg_idx_e idx;
    for (int i = 0; i < NumRegs; i++) begin
      idx = reg_idx_e'(i);
      apb_write(idx, {pick_value(1'b0), pick_value(1'b0)});
    end
  endtask

  task automatic load_all(logic [63:0] value);
    for (int i = 0; i < NumRegs; i++) apb_write(reg_idx_e'(i), value);
  endtask

  task automatic push_random(int n);
    point_row_t row;
    for (int i = 0; i < n; i++) begin
      row = '0;
      row.mode = ($urandom_range(3) == 0) ? MODE_DIR : MODE_POINT;
      row.x = pick_value(1'b1);
      row.y = pick_value(1'b1);
      row.z = pick_value(1'b1);
      pending_points.push_back(row);
    end
  endtask

  task automatic wait_idle();
    while (pending_points.size() != 0 || expected_results.size() != 0 || in_bus.valid)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // input side: hold data until transfer, then fetch next
  always @(posedge clk_i) begin
    if (rst_ni && (!in_bus.valid || in_bus.ready)) begin
      if (in_bus.valid) begin
        if (cur_point.typed) expected_results.push_back(cur_point.result);
        else expected_results.push_back(transform_point(in_bus.data));
      end
      if (pending_points.size() != 0 && !(idle_on && $urandom_range(99) < 6)) begin
        cur_point = pending_points.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.data <= in_t'{cur_point.mode, cur_point.x, cur_point.y, cur_point.z};
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // output side: random stalls, check each transfer against oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", out_bus.data.result_x, 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (out_bus.data.result_x !== want.result_x)
            report_mismatch("result_x", out_bus.data.result_x, want.result_x);
          if (out_bus.data.result_y !== want.result_y)
            report_mismatch("result_y", out_bus.data.result_y, want.result_y);
          if (out_bus.data.result_z !== want.result_z)
            report_mismatch("result_z", out_bus.data.result_z, want.result_z);
          if (out_bus.data.saturated !== want.saturated)
            report_mismatch("saturated", 32'(out_bus.data.saturated), 32'(want.saturated));
        end
      end
      out_bus.ready <= !(idle_on && $urandom_range(99) < 6);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    matrix = '{64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
               64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (IdentityRows[i]) pending_points.push_back(IdentityRows[i]);
    wait_idle();

    // projective row picks up z, so w = z
    apb_write(REG_ROW3_C23, 64'h0001_0000_0000_0000);
    foreach (PerspRows[i]) pending_points.push_back(PerspRows[i]);
    push_random(RandPerPhase);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      load_random_matrix();
      idle_on = (ph != 1);  // one long stretch with no idling
      push_random(RandPerPhase);
      wait_idle();
    end
    idle_on = 1'b1;

    load_all(64'h8000_0000_8000_0000);
    push_random(RandPerPhase / 2);
    wait_idle();
    load_all(64'h7fff_ffff_7fff_ffff);
    push_random(RandPerPhase / 2);
    wait_idle();
    load_all(64'h0);
    push_random(RandPerPhase / 4);
    wait_idle();
    load_random_matrix();
    apb_write(REG_ROW3_C01, 64'h0);
    push_random(RandPerPhase);
    wait_idle();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: homogeneous_point_transform_unit.f
+incdir+design
design/hpt_pkg.sv
design/hpt_if.sv
design/homogeneous_point_transform_unit.sv
tb/tb_top.sv
